// ===== sv/lhps_pkg.sv =====
package lhps_pkg;

   localparam int ENTRIES = 65536;
   localparam int IDX_W   = $clog2(ENTRIES);

   // input queue between front and back, power of two
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   localparam logic ACT_PROBE = 1'b0;
   localparam logic ACT_STORE = 1'b1;

   localparam logic [1:0] BOUND_EMPTY = 2'd0;

   typedef struct packed {
      logic              is_store;
      logic [IDX_W-1:0]  index;
      logic [63:0]       key;
      logic signed [15:0] score;
      logic signed [15:0] depth;
      logic signed [15:0] static_eval;
      logic [15:0]       move;
      logic [1:0]        bound;
   } item_type;

   typedef struct packed {
      logic [63:0]        check;
      logic [15:0]        move;
      logic [7:0]         age;
      logic [1:0]         bound;
      logic signed [15:0] static_eval;
      logic signed [15:0] depth;
      logic signed [15:0] score;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               hit;
      logic               written;
      logic signed [15:0] score;
      logic signed [15:0] depth;
      logic signed [15:0] static_eval;
      logic [15:0]        move;
      logic [1:0]         bound;
      logic [7:0]         age;
   } rsp_type;

   // data word: score 0..15, depth 16..31, eval 32..47, bound 48..49, age 56..63
   function automatic logic [63:0] data_word(logic [15:0] score, logic [15:0] depth,
                                             logic [15:0] static_eval, logic [1:0] bound,
                                             logic [7:0] age);
      data_word = {age, 6'b000000, bound, static_eval, depth, score};
   endfunction

endpackage

// ===== sv/lockless_hash_table_probe_store_top.sv =====
// channel   | handshake             | ports
// ----------+-----------------------+--------------------------------------------
// request   | start & !busy         | req_action, req_key, req_new_*
// response  | rsp_valid (strobe)    | rsp_hit, rsp_written, rsp_entry_*
// config    | csr_valid & csr_ready | csr_data (generation)
//
// each item goes through the back end as a table read, issued when it is popped,
// then a compare and write-back on the single write port; a two-beat queue lets
// start be taken while the back end works
// after reset the table is cleared one entry per cycle, all 65536 entries, busy high
// csr writes are taken at any time, csr_ready is always high
// each result is shown for one cycle only, the receiver cannot stall
module lockless_hash_table_probe_store_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [63:0]        req_key,
   input  logic signed [15:0] req_new_score,
   input  logic signed [15:0] req_new_depth,
   input  logic signed [15:0] req_new_static_eval,
   input  logic [15:0]        req_new_move,
   input  logic [1:0]         req_new_bound,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic               rsp_written,
   output logic signed [15:0] rsp_entry_score,
   output logic signed [15:0] rsp_entry_depth,
   output logic signed [15:0] rsp_entry_static_eval,
   output logic [15:0]        rsp_entry_move,
   output logic [1:0]         rsp_entry_bound,
   output logic [7:0]         rsp_entry_age,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_data
);

   logic [7:0]                         generation_ff;
   logic                               clearing;
   logic                               pop;
   logic                               head_valid;
   lhps_pkg::item_type                 head;
   logic                               ram_we;
   logic [lhps_pkg::IDX_W-1:0]         ram_waddr;
   logic [lhps_pkg::ENTRY_W-1:0]       ram_wdata;
   logic [lhps_pkg::IDX_W-1:0]         ram_raddr;
   logic [lhps_pkg::ENTRY_W-1:0]       ram_rdata;
   lhps_pkg::rsp_type                  rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         generation_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         generation_ff <= csr_data;
      end
   end

   lhps_front u_front (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .req_action          (req_action),
      .req_key             (req_key),
      .req_new_score       (req_new_score),
      .req_new_depth       (req_new_depth),
      .req_new_static_eval (req_new_static_eval),
      .req_new_move        (req_new_move),
      .req_new_bound       (req_new_bound),
      .clearing            (clearing),
      .pop                 (pop),
      .busy                (busy),
      .head_valid          (head_valid),
      .head                (head)
   );

   lhps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .generation (generation_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   lhps_ram #(
      .WIDTH (lhps_pkg::ENTRY_W),
      .DEPTH (lhps_pkg::ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_hit               = rsp.hit;
   assign rsp_written           = rsp.written;
   assign rsp_entry_score       = rsp.score;
   assign rsp_entry_depth       = rsp.depth;
   assign rsp_entry_static_eval = rsp.static_eval;
   assign rsp_entry_move        = rsp.move;
   assign rsp_entry_bound       = rsp.bound;
   assign rsp_entry_age         = rsp.age;

endmodule

// ===== sv/lhps_ram.sv =====
module lhps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/lhps_front.sv =====
module lhps_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_action,
   input  logic [63:0]         req_key,
   input  logic signed [15:0]  req_new_score,
   input  logic signed [15:0]  req_new_depth,
   input  logic signed [15:0]  req_new_static_eval,
   input  logic [15:0]         req_new_move,
   input  logic [1:0]          req_new_bound,
   input  logic                clearing,
   input  logic                pop,
   output logic                busy,
   output logic                head_valid,
   output lhps_pkg::item_type  head
);

   lhps_pkg::item_type                 q_ff [lhps_pkg::QDEPTH];
   logic [lhps_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [lhps_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [lhps_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   lhps_pkg::item_type                 item;
   logic                               push;
   logic                               full;

   always_comb begin
      item.is_store    = (req_action == lhps_pkg::ACT_STORE);
      item.index       = req_key[lhps_pkg::IDX_W-1:0];
      item.key         = req_key;
      item.score       = req_new_score;
      item.depth       = req_new_depth;
      item.static_eval = req_new_static_eval;
      item.move        = req_new_move;
      item.bound       = req_new_bound;
   end

   assign full       = (cnt_ff == lhps_pkg::QCNT_W'(lhps_pkg::QDEPTH));
   assign busy       = clearing || full;
   assign push       = start && !busy;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== sv/lhps_back.sv =====
module lhps_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     generation,
   input  logic                           head_valid,
   input  lhps_pkg::item_type             head,
   output logic                           pop,
   output logic                           clearing,
   output logic                           ram_we,
   output logic [lhps_pkg::IDX_W-1:0]     ram_waddr,
   output logic [lhps_pkg::ENTRY_W-1:0]   ram_wdata,
   output logic [lhps_pkg::IDX_W-1:0]     ram_raddr,
   input  logic [lhps_pkg::ENTRY_W-1:0]   ram_rdata,
   output logic                           rsp_valid,
   output lhps_pkg::rsp_type              rsp
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   localparam logic [lhps_pkg::IDX_W-1:0] LAST_IDX = lhps_pkg::IDX_W'(lhps_pkg::ENTRIES - 1);

   logic [1:0]                 state_ff, state_in;
   logic [lhps_pkg::IDX_W-1:0] clr_cnt_ff, clr_cnt_in;
   lhps_pkg::item_type         cur_ff, cur_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lhps_pkg::rsp_type          rsp_ff, rsp_in;

   lhps_pkg::entry_type        old_entry;
   lhps_pkg::entry_type        new_entry;
   lhps_pkg::entry_type        after_entry;
   logic                       empty;
   logic                       stale;
   logic                       deeper;
   logic                       allow;
   logic                       hit;

   // classify the entry read for the current item
   always_comb begin
      old_entry = lhps_pkg::entry_type'(ram_rdata);
      empty     = (old_entry.bound == lhps_pkg::BOUND_EMPTY);
      stale     = (old_entry.age != generation);
      deeper    = (cur_ff.depth >= old_entry.depth);
      allow     = cur_ff.is_store && (empty || stale || deeper);
      hit       = !cur_ff.is_store && !empty
                  && ((old_entry.check ^ lhps_pkg::data_word(old_entry.score, old_entry.depth,
                       old_entry.static_eval, old_entry.bound, old_entry.age)) == cur_ff.key);

      new_entry.score       = cur_ff.score;
      new_entry.depth       = cur_ff.depth;
      new_entry.static_eval = cur_ff.static_eval;
      new_entry.bound       = cur_ff.bound;
      new_entry.age         = generation;
      new_entry.move        = cur_ff.move;
      new_entry.check       = cur_ff.key ^ lhps_pkg::data_word(cur_ff.score, cur_ff.depth,
                                 cur_ff.static_eval, cur_ff.bound, generation);

      after_entry = allow ? new_entry : old_entry;
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff.index;
      ram_wdata    = new_entry;
      ram_raddr    = head.index;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_cnt_ff;
            ram_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               cur_in   = head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // write lands before the next item's read is issued
            ram_we             = allow;
            rsp_valid_in       = 1'b1;
            rsp_in.hit         = hit;
            rsp_in.written     = allow;
            rsp_in.score       = after_entry.score;
            rsp_in.depth       = after_entry.depth;
            rsp_in.static_eval = after_entry.static_eval;
            rsp_in.move        = after_entry.move;
            rsp_in.bound       = after_entry.bound;
            rsp_in.age         = after_entry.age;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == ST_EXEC)
      else $error("result without an executed item");

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop)
      else $error("item taken while table clears");

   a_probe_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !cur_ff.is_store) |-> !ram_we && !rsp_in.written)
      else $error("probe wrote the table");

endmodule
